// File: hdl/aeskx_pkg.sv
// Package for the AES-128 key expansion unit: word types, S-box and round constant tables,
// and the round key step function.
// No dependencies.
package aeskx_pkg;

	localparam int unsigned ROUND_KEYS = 11;
	localparam logic [3:0] LAST_ROUND = 4'(ROUND_KEYS - 1);

	// Cipher key word as it arrives.
	typedef struct packed {
		logic [63:0] key_high;
		logic [63:0] key_low;
	} key_word_t;

	// Round key word as it leaves.
	typedef struct packed {
		logic [3:0]  round_index;
		logic [63:0] round_key_high;
		logic [63:0] round_key_low;
		logic        last_key;
	} rkey_word_t;

	localparam logic [7:0] SBOX [0:255] = '{
		8'h63,8'h7c,8'h77,8'h7b,8'hf2,8'h6b,8'h6f,8'hc5,8'h30,8'h01,8'h67,8'h2b,8'hfe,8'hd7,8'hab,8'h76,
		8'hca,8'h82,8'hc9,8'h7d,8'hfa,8'h59,8'h47,8'hf0,8'had,8'hd4,8'ha2,8'haf,8'h9c,8'ha4,8'h72,8'hc0,
		8'hb7,8'hfd,8'h93,8'h26,8'h36,8'h3f,8'hf7,8'hcc,8'h34,8'ha5,8'he5,8'hf1,8'h71,8'hd8,8'h31,8'h15,
		8'h04,8'hc7,8'h23,8'hc3,8'h18,8'h96,8'h05,8'h9a,8'h07,8'h12,8'h80,8'he2,8'heb,8'h27,8'hb2,8'h75,
		8'h09,8'h83,8'h2c,8'h1a,8'h1b,8'h6e,8'h5a,8'ha0,8'h52,8'h3b,8'hd6,8'hb3,8'h29,8'he3,8'h2f,8'h84,
		8'h53,8'hd1,8'h00,8'hed,8'h20,8'hfc,8'hb1,8'h5b,8'h6a,8'hcb,8'hbe,8'h39,8'h4a,8'h4c,8'h58,8'hcf,
		8'hd0,8'hef,8'haa,8'hfb,8'h43,8'h4d,8'h33,8'h85,8'h45,8'hf9,8'h02,8'h7f,8'h50,8'h3c,8'h9f,8'ha8,
		8'h51,8'ha3,8'h40,8'h8f,8'h92,8'h9d,8'h38,8'hf5,8'hbc,8'hb6,8'hda,8'h21,8'h10,8'hff,8'hf3,8'hd2,
		8'hcd,8'h0c,8'h13,8'hec,8'h5f,8'h97,8'h44,8'h17,8'hc4,8'ha7,8'h7e,8'h3d,8'h64,8'h5d,8'h19,8'h73,
		8'h60,8'h81,8'h4f,8'hdc,8'h22,8'h2a,8'h90,8'h88,8'h46,8'hee,8'hb8,8'h14,8'hde,8'h5e,8'h0b,8'hdb,
		8'he0,8'h32,8'h3a,8'h0a,8'h49,8'h06,8'h24,8'h5c,8'hc2,8'hd3,8'hac,8'h62,8'h91,8'h95,8'he4,8'h79,
		8'he7,8'hc8,8'h37,8'h6d,8'h8d,8'hd5,8'h4e,8'ha9,8'h6c,8'h56,8'hf4,8'hea,8'h65,8'h7a,8'hae,8'h08,
		8'hba,8'h78,8'h25,8'h2e,8'h1c,8'ha6,8'hb4,8'hc6,8'he8,8'hdd,8'h74,8'h1f,8'h4b,8'hbd,8'h8b,8'h8a,
		8'h70,8'h3e,8'hb5,8'h66,8'h48,8'h03,8'hf6,8'h0e,8'h61,8'h35,8'h57,8'hb9,8'h86,8'hc1,8'h1d,8'h9e,
		8'he1,8'hf8,8'h98,8'h11,8'h69,8'hd9,8'h8e,8'h94,8'h9b,8'h1e,8'h87,8'he9,8'hce,8'h55,8'h28,8'hdf,
		8'h8c,8'ha1,8'h89,8'h0d,8'hbf,8'he6,8'h42,8'h68,8'h41,8'h99,8'h2d,8'h0f,8'hb0,8'h54,8'hbb,8'h16
	};

	// Round constant used to derive round key r+1 from round key r.
	function automatic logic [7:0] rcon(input logic [3:0] round);
		logic [7:0] c;
		unique case (round)
			4'd0:    c = 8'h01;
			4'd1:    c = 8'h02;
			4'd2:    c = 8'h04;
			4'd3:    c = 8'h08;
			4'd4:    c = 8'h10;
			4'd5:    c = 8'h20;
			4'd6:    c = 8'h40;
			4'd7:    c = 8'h80;
			4'd8:    c = 8'h1b;
			4'd9:    c = 8'h36;
			default: c = 8'h00;
		endcase
		return c;
	endfunction

	// Rotate left by one byte, then substitute each byte.
	function automatic logic [31:0] rot_sub_word(input logic [31:0] w);
		logic [31:0] r;
		r = {w[23:0], w[31:24]};
		return {SBOX[r[31:24]], SBOX[r[23:16]], SBOX[r[15:8]], SBOX[r[7:0]]};
	endfunction

	// One step of the expansion: the next round key from the current one.
	function automatic logic [127:0] next_round_key(input logic [127:0] k,
		input logic [7:0] rc);
		logic [31:0] w0, w1, w2, w3;
		w0 = k[127:96] ^ rot_sub_word(k[31:0]) ^ {rc, 24'h000000};
		w1 = k[95:64] ^ w0;
		w2 = k[63:32] ^ w1;
		w3 = k[31:0] ^ w2;
		return {w0, w1, w2, w3};
	endfunction

endpackage

// File: hdl/aes128_key_expansion_unit.sv
// AES-128 key expansion unit: expands one cipher key into its eleven round keys.
// Depends on aeskx_pkg.
//
// Each cipher key word accepted on the key channel yields eleven round key words on the
// rkey channel, round 0 (the cipher key itself) first and round 10 last, marked by last_key.
// One round key leaves per cycle while the output is not stalled. This rate is set by the
// single round key register: each output handshake but the last replaces its contents with
// the next round key, computed in one pass of the rotate, S-box, round constant and chained
// XOR logic. A new cipher key is taken in the very cycle in which the last round key of the
// previous one is taken, so round 0 of the next key directly follows round 10 of the
// previous one. Nothing is kept between cipher keys.
module aes128_key_expansion_unit (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  key_valid,
	output logic                  key_ready,
	input  aeskx_pkg::key_word_t  key,
	output logic                  rkey_valid,
	input  logic                  rkey_ready,
	output aeskx_pkg::rkey_word_t rkey
);

	// Current round key, its round number and whether it is on offer.
	logic [127:0] rkey_q;
	logic [3:0]   round_q;
	logic         valid_q;

	logic         last;
	logic         key_take;
	logic         rkey_take;
	logic [127:0] next_key;

	assign last      = (round_q == aeskx_pkg::LAST_ROUND);
	assign rkey_take = valid_q && rkey_ready;

	// A new cipher key may enter when nothing is on offer, or when the final round key of
	// the current cipher key leaves in this cycle.
	assign key_ready = !valid_q || (rkey_ready && last);
	assign key_take  = key_valid && key_ready;

	assign next_key = aeskx_pkg::next_round_key(rkey_q, aeskx_pkg::rcon(round_q));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
			round_q <= '0;
		end else begin
			priority if (key_take) begin
				valid_q <= 1'b1;
				round_q <= '0;
			end else if (rkey_take) begin
				if (last) begin
					valid_q <= 1'b0;
				end else begin
					round_q <= round_q + 4'd1;
				end
			end
		end
	end

	// Payload register: loaded with the cipher key, then stepped on each output handshake but the last.
	always_ff @(posedge clk) begin
		priority if (key_take) begin
			rkey_q <= {key.key_high, key.key_low};
		end else if (rkey_take && !last) begin
			rkey_q <= next_key;
		end
	end

	assign rkey_valid          = valid_q;
	assign rkey.round_index    = round_q;
	assign rkey.round_key_high = rkey_q[127:64];
	assign rkey.round_key_low  = rkey_q[63:0];
	assign rkey.last_key       = last;

endmodule

// File: hdl/aeskx_checker.sv
// Port-level checker for the AES-128 key expansion unit, with its bind statement.
// Depends on aeskx_pkg and aes128_key_expansion_unit.
module aeskx_checker (
	input logic                  clk,
	input logic                  arst_n,
	input logic                  key_valid,
	input logic                  key_ready,
	input aeskx_pkg::key_word_t  key,
	input logic                  rkey_valid,
	input logic                  rkey_ready,
	input aeskx_pkg::rkey_word_t rkey
);

	// A cipher key taken appears next as round key 0 with the same bits.
	a_key_to_round0: assert property (@(posedge clk) disable iff (!arst_n)
		key_valid && key_ready |=> rkey_valid && rkey.round_index == 4'd0 &&
		rkey.round_key_high == $past(key.key_high) &&
		rkey.round_key_low == $past(key.key_low))
		else $error("cipher key did not appear as round key 0");

	// A round key taken before the last is followed by the next round.
	a_round_advance: assert property (@(posedge clk) disable iff (!arst_n)
		rkey_valid && rkey_ready && !rkey.last_key |=>
		rkey_valid && rkey.round_index == $past(rkey.round_index) + 4'd1)
		else $error("round index did not advance");

	// The last mark sits on round 10 and nowhere else.
	a_last_mark: assert property (@(posedge clk) disable iff (!arst_n)
		rkey_valid |-> (rkey.last_key == (rkey.round_index == aeskx_pkg::LAST_ROUND)))
		else $error("last_key does not match round 10");

	// With nothing on offer the block is ready for a new cipher key.
	a_ready_when_empty: assert property (@(posedge clk) disable iff (!arst_n)
		!rkey_valid |-> key_ready)
		else $error("key channel blocked while output is empty");

	// A stalled round key word holds.
	a_stall_hold: assert property (@(posedge clk) disable iff (!arst_n)
		rkey_valid && !rkey_ready |=> rkey_valid && $stable(rkey))
		else $error("stalled round key word changed");

endmodule

bind aes128_key_expansion_unit aeskx_checker u_aeskx_checker (
	.clk        (clk),
	.arst_n     (arst_n),
	.key_valid  (key_valid),
	.key_ready  (key_ready),
	.key        (key),
	.rkey_valid (rkey_valid),
	.rkey_ready (rkey_ready),
	.rkey       (rkey)
);
